// File: design/ising_delta_energy_engine_assert.svh
// Assertion macros for the Ising delta-energy engine
`ifndef ISING_DELTA_ENERGY_ENGINE_ASSERT_SVH
`define ISING_DELTA_ENERGY_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define IDE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ide_pkg.sv
// Shared types and constants for the Ising delta-energy engine
`default_nettype none

package ide_pkg;

  localparam int ROW_W        = 5;
  localparam int SPIN_FIELD_W = 32;
  localparam int IDX_W        = 6;

  typedef enum logic [1:0] {
    CMD_WR_COUPLING = 2'd0,
    CMD_WR_BIAS     = 2'd1,
    CMD_LOCAL       = 2'd2,
    CMD_UNIFORM     = 2'd3
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic last;
  } beat_tag_t;

  typedef struct packed {
    logic             uniform;
    logic [IDX_W-1:0] k;
    logic             s_k;
  } lane_ctl_t;

endpackage

`default_nettype wire

// File: design/ide_ram.sv
// Generic simple dual-port RAM with registered read
`default_nettype none

module ide_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/ide_lane.sv
// One coupling lane: signs or masks the coupling of its column
`default_nettype none

module ide_lane #(
  parameter int LANE      = 0,
  parameter int COEF_BITS = 40
) (
  input  logic                  clk,
  input  ide_pkg::lane_ctl_t    ctl,
  input  logic                  spin_j,
  input  logic [COEF_BITS-1:0]  coupling,
  output logic [COEF_BITS-1:0]  term
);

  import ide_pkg::*;

  localparam logic [IDX_W-1:0] LANE_IDX = IDX_W'(LANE);

  logic [COEF_BITS-1:0] neg;
  logic [COEF_BITS-1:0] term_next;

  always_comb begin
    neg = COEF_BITS'(0) - coupling;
    if (ctl.uniform) begin
      // upper triangle only; aligned spins lower the energy
      if (LANE_IDX > ctl.k) begin
        term_next = (spin_j == ctl.s_k) ? neg : coupling;
      end else begin
        term_next = '0;
      end
    end else begin
      if (LANE_IDX == ctl.k) begin
        term_next = '0;
      end else begin
        term_next = spin_j ? coupling : neg;
      end
    end
  end

  always_ff @(posedge clk) begin
    term <= term_next;
  end

endmodule

`default_nettype wire

// File: design/ide_merge.sv
// Registered adder tree merging the lane terms
`default_nettype none

module ide_merge #(
  parameter int LEAVES    = 33,
  parameter int COEF_BITS = 40
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [COEF_BITS-1:0]  leaf [LEAVES],
  input  ide_pkg::beat_tag_t    tag_in,
  output logic [COEF_BITS-1:0]  sum,
  output ide_pkg::beat_tag_t    tag_out
);

  import ide_pkg::*;

  localparam int LEVELS = $clog2(LEAVES);
  localparam int P2     = 1 << LEVELS;

  logic [COEF_BITS-1:0] node [LEVELS+1][P2];
  beat_tag_t            tag_pipe [LEVELS+1];

  genvar l, n;

  for (n = 0; n < P2; n++) begin : g_leaf
    if (n < LEAVES) begin : g_real
      assign node[0][n] = leaf[n];
    end else begin : g_pad
      assign node[0][n] = '0;
    end
  end

  assign tag_pipe[0] = tag_in;

  for (l = 1; l <= LEVELS; l++) begin : g_level
    for (n = 0; n < (P2 >> l); n++) begin : g_node
      always_ff @(posedge clk) begin
        node[l][n] <= node[l-1][2*n] + node[l-1][2*n+1];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        tag_pipe[l] <= '0;
      end else begin
        tag_pipe[l] <= tag_pipe[l-1];
      end
    end
  end

  assign sum     = node[LEVELS][0];
  assign tag_out = tag_pipe[LEVELS];

endmodule

`default_nettype wire

// File: design/ising_delta_energy_engine.sv
// Top level of the Ising delta-energy engine
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_stall    cmd, row, col, coef, spins, prev_energy
//   out      out  out_valid/out_stall  delta_energy
//
// Table writes are taken while idle; the next beat may follow at once.
// Local query: one row read, lane stage, adder tree levels, final scaling.
// Uniform query: reads one coupling row per cycle from the lane RAMs.
// One query in flight; a pending result may sit in the output register while
// the next beat is taken. rst is synchronous and clears control only.
`default_nettype none

module ising_delta_energy_engine #(
  parameter int SPINS     = 32,
  parameter int COEF_BITS = 40
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           cmd,
  input  logic [ide_pkg::ROW_W-1:0]            row,
  input  logic [ide_pkg::ROW_W-1:0]            col,
  input  logic signed [COEF_BITS-1:0]          coef,
  input  logic [ide_pkg::SPIN_FIELD_W-1:0]     spins,
  input  logic signed [COEF_BITS-1:0]          prev_energy,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [COEF_BITS-1:0]          delta_energy
);

  import ide_pkg::*;

  `include "ising_delta_energy_engine_assert.svh"

  localparam int ADDR_W = $clog2(SPINS);
  localparam int LEAVES = SPINS + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BUSY,
    S_FINISH
  } state_t;

  state_t               state;
  logic                 q_uniform;
  logic                 q_row_ok;
  logic                 q_si;
  logic [SPINS-1:0]     q_spins;
  logic [COEF_BITS-1:0] q_old;
  logic                 issuing;
  logic [ADDR_W-1:0]    issue_k;
  logic [COEF_BITS-1:0] acc;

  beat_tag_t            rd_tag;
  logic [ADDR_W-1:0]    rd_k;
  beat_tag_t            lane_tag;
  logic [COEF_BITS-1:0] bias_term;

  logic                 accept;
  logic                 out_free;
  logic                 row_ok;
  logic                 col_ok;
  logic [ADDR_W-1:0]    row_addr;
  logic [ADDR_W-1:0]    col_addr;
  logic                 coup_we;
  logic                 bias_we;
  logic                 issue_last;
  logic [SPINS-1:0]     spin_vec;
  lane_ctl_t            lane_ctl;
  logic [COEF_BITS-1:0] row_data [SPINS];
  logic [COEF_BITS-1:0] terms [SPINS];
  logic [COEF_BITS-1:0] leaves [LEAVES];
  logic [COEF_BITS-1:0] bias_rd;
  logic [COEF_BITS-1:0] merge_sum;
  beat_tag_t            merge_tag;
  logic [COEF_BITS-1:0] dbl;
  logic [COEF_BITS-1:0] final_val;

  // spins past the field read as -1
  for (genvar k = 0; k < SPINS; k++) begin : g_spin
    if (k < SPIN_FIELD_W) begin : g_in
      assign spin_vec[k] = spins[k];
    end else begin : g_out
      assign spin_vec[k] = 1'b0;
    end
  end

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign row_ok   = (32'(row) < 32'(SPINS));
  assign col_ok   = (32'(col) < 32'(SPINS));
  assign row_addr = ADDR_W'(row);
  assign col_addr = ADDR_W'(col);
  assign coup_we  = accept && (cmd == CMD_WR_COUPLING) && row_ok && col_ok;
  assign bias_we  = accept && (cmd == CMD_WR_BIAS) && row_ok;
  assign issue_last = !q_uniform || (issue_k == ADDR_W'(SPINS - 1));

  for (genvar j = 0; j < SPINS; j++) begin : g_lane
    ide_ram #(
      .WIDTH(COEF_BITS),
      .DEPTH(SPINS)
    ) u_cram (
      .clk  (clk),
      .we   (coup_we && (col_addr == ADDR_W'(j))),
      .waddr(row_addr),
      .wdata(coef),
      .raddr(issue_k),
      .rdata(row_data[j])
    );

    ide_lane #(
      .LANE     (j),
      .COEF_BITS(COEF_BITS)
    ) u_lane (
      .clk     (clk),
      .ctl     (lane_ctl),
      .spin_j  (q_spins[j]),
      .coupling(row_data[j]),
      .term    (terms[j])
    );
  end

  ide_ram #(
    .WIDTH(COEF_BITS),
    .DEPTH(SPINS)
  ) u_bram (
    .clk  (clk),
    .we   (bias_we),
    .waddr(row_addr),
    .wdata(coef),
    .raddr(issue_k),
    .rdata(bias_rd)
  );

  always_comb begin
    lane_ctl.uniform = q_uniform;
    lane_ctl.k       = IDX_W'(rd_k);
    lane_ctl.s_k     = q_spins[rd_k];
    for (int j = 0; j < SPINS; j++) begin
      leaves[j] = terms[j];
    end
    leaves[SPINS] = bias_term;
  end

  always_ff @(posedge clk) begin
    rd_k <= issue_k;
    if (q_uniform && q_spins[rd_k]) begin
      bias_term <= COEF_BITS'(0) - bias_rd;
    end else begin
      bias_term <= bias_rd;
    end
    if (rst) begin
      rd_tag   <= '0;
      lane_tag <= '0;
    end else begin
      rd_tag.valid <= issuing;
      rd_tag.last  <= issue_last;
      lane_tag     <= rd_tag;
    end
  end

  ide_merge #(
    .LEAVES   (LEAVES),
    .COEF_BITS(COEF_BITS)
  ) u_merge (
    .clk    (clk),
    .rst    (rst),
    .leaf   (leaves),
    .tag_in (lane_tag),
    .sum    (merge_sum),
    .tag_out(merge_tag)
  );

  always_comb begin
    dbl = {acc[COEF_BITS-2:0], 1'b0};
    if (q_uniform) begin
      final_val = acc - q_old;
    end else if (!q_row_ok) begin
      final_val = '0;
    end else if (q_si) begin
      final_val = dbl;
    end else begin
      final_val = COEF_BITS'(0) - dbl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issuing   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && (cmd == CMD_LOCAL || cmd == CMD_UNIFORM)) begin
            state     <= S_BUSY;
            issuing   <= 1'b1;
            q_uniform <= (cmd == CMD_UNIFORM);
            q_row_ok  <= row_ok;
            q_si      <= row_ok && spin_vec[row_addr];
            q_spins   <= spin_vec;
            q_old     <= prev_energy;
            issue_k   <= (cmd == CMD_UNIFORM) ? '0 : row_addr;
            acc       <= '0;
          end
        end
        S_BUSY: begin
          if (issuing) begin
            if (issue_last) begin
              issuing <= 1'b0;
            end else begin
              issue_k <= issue_k + ADDR_W'(1);
            end
          end
          if (merge_tag.valid) begin
            acc <= acc + merge_sum;
            if (merge_tag.last) begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            delta_energy <= final_val;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `IDE_ASSERT_NOW(a_merge_in_query, merge_tag.valid, state == S_BUSY, "merge beat outside a query")
  `IDE_ASSERT_NOW(a_write_when_idle, coup_we || bias_we, state == S_IDLE, "table write during a query")
  `IDE_ASSERT_NEXT(a_finish_delivers, state == S_FINISH && out_free, out_valid && state == S_IDLE, "finished query not delivered")

endmodule

`default_nettype wire
